// ===== rtl/core/aart_pkg.sv =====
// Shared types, constants and rounding helpers for the axis-angle transform unit.
package aart_pkg;

  // Field widths
  localparam int ANG_W  = 32;
  localparam int DIR_W  = 16;
  localparam int PNT_W  = 32;
  localparam int MAT_W  = 18;
  localparam int SHF_W  = 32;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;
  localparam int TRIG_W = 33;  // Q.30 values with headroom

  // Item queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Horner steps for sine and cosine
  localparam int NSTEP  = 8;

  // Angle constants, Q4.28
  localparam logic signed [ANG_W:0] PI28     = 33'sd843314857;
  localparam logic signed [ANG_W:0] TWOPI28  = 33'sd1686629713;
  localparam logic signed [ANG_W:0] HALFPI28 = 33'sd421657428;

  localparam logic signed [TRIG_W-1:0] ONE30 = 33'sd1073741824;

  // Register indexes
  typedef logic [IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DIR_X   = 3'd0;
  localparam cfg_idx_t REG_DIR_Y   = 3'd1;
  localparam cfg_idx_t REG_DIR_Z   = 3'd2;
  localparam cfg_idx_t REG_POINT_X = 3'd3;
  localparam cfg_idx_t REG_POINT_Y = 3'd4;
  localparam cfg_idx_t REG_POINT_Z = 3'd5;

  // Horner divisors indexed by k-1, and floor(2^33 / d)
  localparam int DIV_W = 10;
  localparam int RECIP_SH = 33;
  localparam int COS_DIV [NSTEP] = '{2, 12, 30, 56, 90, 132, 182, 240};
  localparam int SIN_DIV [NSTEP] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam logic [32:0] COS_RECIP [NSTEP] = '{
    33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689,
    33'd95443717,   33'd65075262,  33'd47197442,  33'd35791394};
  localparam logic [32:0] SIN_RECIP [NSTEP] = '{
    33'd1431655765, 33'd429496729, 33'd204522252, 33'd119304647,
    33'd78090314,   33'd55063683,  33'd40904450,  33'd31580641};

  // Axis configuration
  typedef struct packed {
    logic signed [DIR_W-1:0] u;
    logic signed [DIR_W-1:0] v;
    logic signed [DIR_W-1:0] w;
    logic signed [PNT_W-1:0] a;
    logic signed [PNT_W-1:0] b;
    logic signed [PNT_W-1:0] c;
  } cfg_t;

  // Reduced angle as queued
  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic                    flip;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Sine, cosine and one minus cosine, Q.30
  typedef struct packed {
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] omc;
  } trig_t;

  // v / 2^n, rounded half away from zero
  function automatic logic signed [127:0] rnd_hafz(input logic signed [127:0] v, input int n);
    logic [127:0] m;
    m = v[127] ? 128'(-v) : 128'(v);
    m = (m + (128'd1 << (n - 1))) >> n;
    return v[127] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [MAT_W-1:0] sat_mat(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sd131071;
    lo = -128'sd131072;
    if (v > hi) return hi[MAT_W-1:0];
    else if (v < lo) return lo[MAT_W-1:0];
    else return v[MAT_W-1:0];
  endfunction

  function automatic logic signed [SHF_W-1:0] sat_shf(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) return hi[SHF_W-1:0];
    else if (v < lo) return lo[SHF_W-1:0];
    else return v[SHF_W-1:0];
  endfunction

endpackage

// ===== rtl/core/aart_front.sv =====
// Front end: takes angle items, reduces them to a half turn and hands them to the queue.
module aart_front import aart_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ANG_W-1:0] angle,
  input  qstat_t                  qstat,
  output logic                    push,
  output item_t                   push_item
);

  logic  fvalid;
  item_t fitem;
  logic  adv;
  logic signed [ANG_W:0] r1;
  logic signed [ANG_W:0] r2;
  logic  flip_n;

  assign adv      = !fvalid || !qstat.full;
  assign in_stall = !adv;
  assign push     = fvalid && !qstat.full;
  assign push_item = fitem;

  // Wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    r1 = (ANG_W + 1)'(angle);
    if (r1 > PI28) r1 = r1 - TWOPI28;
    else if (r1 < -PI28) r1 = r1 + TWOPI28;
    r2 = r1;
    flip_n = 1'b0;
    if (r1 > HALFPI28) begin
      r2 = r1 - PI28;
      flip_n = 1'b1;
    end else if (r1 < -HALFPI28) begin
      r2 = r1 + PI28;
      flip_n = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (adv) begin
      fvalid <= in_valid;
    end
  end

  // Residue times four gives Q.30
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      fitem.x    <= {r2[ANG_W-3:0], 2'b00};
      fitem.flip <= flip_n;
    end
  end

endmodule

// ===== rtl/core/aart_queue.sv =====
// Short item queue between the front end and the arithmetic back end.
module aart_queue import aart_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output qstat_t qstat,
  output item_t  head
);

  item_t slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign qstat.full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/core/aart_back.sv =====
// Back end: pipelined Horner evaluation of sine and cosine for queued items.
module aart_back import aart_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  qstat_t qstat,
  input  item_t head,
  output logic  pop,
  output trig_t trig,
  output logic  trig_valid
);

  typedef struct packed {
    logic signed [ANG_W-1:0]  x;
    logic signed [TRIG_W-1:0] x2;
    logic                     flip;
  } carry_t;

  assign pop = en && !qstat.empty;

  // x squared
  logic                 v0;
  item_t                it0;
  logic signed [63:0]   xx0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= pop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= head;
      xx0 <= 64'(head.x) * 64'(head.x);
    end
  end

  // Horner step inputs and outputs
  logic                     vs   [NSTEP+1];
  carry_t                   cc   [NSTEP+1];
  logic signed [TRIG_W-1:0] cs_s [NSTEP+1];
  logic signed [TRIG_W-1:0] sn_s [NSTEP+1];
  logic signed [127:0]      x2_w;

  assign x2_w = rnd_hafz(128'(xx0), 30);

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else if (en) vs[0] <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc[0].x    <= it0.x;
      cc[0].flip <= it0.flip;
      cc[0].x2   <= x2_w[TRIG_W-1:0];
      cs_s[0]    <= ONE30;
      sn_s[0]    <= ONE30;
    end
  end

  // One Horner step per k, three stages each: product, round and divide, correct
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam int K = NSTEP - i;
    localparam logic [32:0] RC = COS_RECIP[K-1];
    localparam logic [32:0] RS = SIN_RECIP[K-1];
    localparam logic [32:0] DC = 33'(COS_DIV[K-1]);
    localparam logic [32:0] DS = 33'(SIN_DIV[K-1]);

    logic va, vb;
    carry_t ca, cb;
    logic signed [65:0] pc, ps;
    logic signed [127:0] rc_w, rs_w;
    logic [32:0] mc_n, ms_n;
    logic [65:0] qc_p, qs_p;
    logic [32:0] magc, mags, q0c, q0s;
    logic negc, negs;
    logic [42:0] qdc, qds;
    logic [32:0] remc, rems, qc, qs;
    logic signed [TRIG_W-1:0] valc, vals;
    logic signed [TRIG_W-1:0] cs_next, sn_next;

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
        vb <= 1'b0;
        vs[i+1] <= 1'b0;
      end else if (en) begin
        va <= vs[i];
        vb <= va;
        vs[i+1] <= vb;
      end
    end

    // Product with x squared
    always_ff @(posedge clk) begin
      if (en) begin
        ca <= cc[i];
        pc <= 66'(cc[i].x2) * 66'(cs_s[i]);
        ps <= 66'(cc[i].x2) * 66'(sn_s[i]);
      end
    end

    // Round to Q.30, then estimate the quotient by reciprocal
    always_comb begin
      rc_w = rnd_hafz(128'(pc), 30);
      rs_w = rnd_hafz(128'(ps), 30);
      mc_n = rc_w[127] ? 33'(-rc_w) : rc_w[32:0];
      ms_n = rs_w[127] ? 33'(-rs_w) : rs_w[32:0];
      qc_p = 66'(mc_n) * 66'(RC);
      qs_p = 66'(ms_n) * 66'(RS);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cb   <= ca;
        magc <= mc_n;
        mags <= ms_n;
        q0c  <= qc_p[65:RECIP_SH];
        q0s  <= qs_p[65:RECIP_SH];
        negc <= rc_w[127];
        negs <= rs_w[127];
      end
    end

    // Estimate is low by at most one; truncate toward zero
    always_comb begin
      qdc  = 43'(q0c) * 43'(DC);
      qds  = 43'(q0s) * 43'(DS);
      remc = magc - qdc[32:0];
      rems = mags - qds[32:0];
      qc   = q0c + ((remc >= DC) ? 33'd1 : 33'd0);
      qs   = q0s + ((rems >= DS) ? 33'd1 : 33'd0);
      valc = negc ? -$signed(qc) : $signed(qc);
      vals = negs ? -$signed(qs) : $signed(qs);
      cs_next = ONE30 - valc;
      sn_next = ONE30 - vals;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cc[i+1]   <= cb;
        cs_s[i+1] <= cs_next;
        sn_s[i+1] <= sn_next;
      end
    end
  end

  // Sine times x, then undo the half-turn fold
  logic                     vf;
  logic signed [64:0]       xs;
  logic signed [TRIG_W-1:0] csf;
  logic                     flipf;
  logic signed [127:0]      sn_w;
  logic signed [TRIG_W-1:0] cs_o, sn_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      trig_valid <= 1'b0;
    end else if (en) begin
      vf <= vs[NSTEP];
      trig_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs    <= 65'(cc[NSTEP].x) * 65'(sn_s[NSTEP]);
      csf   <= cs_s[NSTEP];
      flipf <= cc[NSTEP].flip;
    end
  end

  always_comb begin
    sn_w = rnd_hafz(128'(xs), 30);
    cs_o = flipf ? -csf : csf;
    sn_o = flipf ? -sn_w[TRIG_W-1:0] : sn_w[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig.cs  <= cs_o;
      trig.sn  <= sn_o;
      trig.omc <= ONE30 - cs_o;
    end
  end

endmodule

// ===== rtl/core/aart_xform.sv =====
// Back end: rotation matrix and translation from sine, cosine and the axis setup.
module aart_xform import aart_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  cfg_t                    cfg,
  input  logic                    trig_valid,
  input  trig_t                   trig,
  output logic                    out_valid,
  output logic signed [MAT_W-1:0] mat [9],
  output logic signed [SHF_W-1:0] shf [3]
);

  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  logic signed [DIR_W-1:0] d [3];
  logic signed [PNT_W-1:0] p [3];

  assign d[0] = cfg.u;
  assign d[1] = cfg.v;
  assign d[2] = cfg.w;
  assign p[0] = cfg.a;
  assign p[1] = cfg.b;
  assign p[2] = cfg.c;

  // Axis terms run free; user changes setup only while block is idle, unenforced
  logic signed [31:0] sq [3];
  logic signed [31:0] dd01, dd02, dd12;
  logic signed [47:0] pd [3];
  logic signed [47:0] cra [3];
  logic signed [47:0] crb [3];
  logic signed [32:0] ssum [3];
  logic signed [48:0] isum [3];
  logic signed [48:0] q30 [3];
  logic signed [64:0] ax [3];
  logic signed [64:0] ux [3];
  logic signed [64:0] p44 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i]   <= 32'(d[i]) * 32'(d[i]);
      pd[i]   <= 48'(p[i]) * 48'(d[i]);
      cra[i]  <= 48'(p[NX1[i]]) * 48'(d[NX2[i]]);
      crb[i]  <= 48'(p[NX2[i]]) * 48'(d[NX1[i]]);
      ssum[i] <= 33'(sq[NX1[i]]) + 33'(sq[NX2[i]]);
      isum[i] <= 49'(pd[NX1[i]]) + 49'(pd[NX2[i]]);
      q30[i]  <= 49'(cra[i]) - 49'(crb[i]);
      ax[i]   <= 65'(p[i]) * 65'(ssum[i]);
      ux[i]   <= 65'(d[i]) * 65'(isum[i]);
      p44[i]  <= ax[i] - ux[i];
    end
    dd01 <= 32'(d[0]) * 32'(d[1]);
    dd02 <= 32'(d[0]) * 32'(d[2]);
    dd12 <= 32'(d[1]) * 32'(d[2]);
  end

  // Item pipeline valid bits
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= trig_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // Products with sine and one minus cosine; wide ones in two halves
  logic signed [64:0] mdg [3];
  logic signed [64:0] m01, m02, m12;
  logic signed [48:0] sd [3];
  logic signed [TRIG_W-1:0] cs1;
  logic signed [65:0] hp [3];
  logic signed [65:0] lp [3];
  logic signed [49:0] hq [3];
  logic signed [65:0] lq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mdg[i] <= 65'(sq[i]) * 65'(trig.omc);
        sd[i]  <= 49'(d[i]) * 49'(trig.sn);
        hp[i]  <= 66'($signed(p44[i][64:32])) * 66'(trig.omc);
        lp[i]  <= 66'($signed({1'b0, p44[i][31:0]})) * 66'(trig.omc);
        hq[i]  <= 50'($signed(q30[i][48:32])) * 50'(trig.sn);
        lq[i]  <= 66'($signed({1'b0, q30[i][31:0]})) * 66'(trig.sn);
      end
      m01 <= 65'(dd01) * 65'(trig.omc);
      m02 <= 65'(dd02) * 65'(trig.omc);
      m12 <= 65'(dd12) * 65'(trig.omc);
      cs1 <= trig.cs;
    end
  end

  // Matrix sums in Q.58, translation products reassembled
  logic signed [65:0] e [9];
  logic signed [97:0] f [3];
  logic signed [81:0] g [3];
  logic signed [65:0] c58;
  logic signed [65:0] sk [3];

  always_comb begin
    c58 = 66'(cs1) <<< 28;
    for (int i = 0; i < 3; i++) sk[i] = 66'(sd[i]) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e[0] <= c58 + 66'(mdg[0]);
      e[1] <= 66'(m01) - sk[2];
      e[2] <= 66'(m02) + sk[1];
      e[3] <= 66'(m01) + sk[2];
      e[4] <= c58 + 66'(mdg[1]);
      e[5] <= 66'(m12) - sk[0];
      e[6] <= 66'(m02) - sk[1];
      e[7] <= 66'(m12) + sk[0];
      e[8] <= c58 + 66'(mdg[2]);
      for (int i = 0; i < 3; i++) begin
        f[i] <= (98'(hp[i]) <<< 32) + 98'(lp[i]);
        g[i] <= (82'(hq[i]) <<< 32) + 82'(lq[i]);
      end
    end
  end

  // Round to output formats
  logic signed [MAT_W-1:0] m3 [9];
  logic signed [40:0] tf [3];
  logic signed [38:0] tg [3];
  logic signed [127:0] tf_w [3];
  logic signed [127:0] tg_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tf_w[i] = rnd_hafz(128'(f[i]), 58);
      tg_w[i] = rnd_hafz(128'(g[i]), 44);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) m3[j] <= sat_mat(rnd_hafz(128'(e[j]), 42));
      for (int i = 0; i < 3; i++) begin
        tf[i] <= tf_w[i][40:0];
        tg[i] <= tg_w[i][38:0];
      end
    end
  end

  // Output register: translation sum saturates
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) mat[j] <= m3[j];
      for (int i = 0; i < 3; i++) shf[i] <= sat_shf(128'(42'(tf[i]) + 42'(tg[i])));
    end
  end

endmodule

// ===== rtl/core/axis_angle_rigid_transform_unit.sv =====
// Top level of the axis-angle rigid transform unit.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    angle (Q4.28)
//  out      output     out_valid / out_stall  r00..r22 (Q2.16), shift_x..z (Q16.16)
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; the sine/cosine pipe is
// built from eight three-stage Horner steps.
// Reset clears the setup registers, the queue and all valid bits.
// out_stall freezes the back end while a result is offered; the four-entry queue
// and front register keep taking items until they fill, then in_stall rises.
module axis_angle_rigid_transform_unit import aart_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [MAT_W-1:0] r00,
  output logic signed [MAT_W-1:0] r01,
  output logic signed [MAT_W-1:0] r02,
  output logic signed [MAT_W-1:0] r10,
  output logic signed [MAT_W-1:0] r11,
  output logic signed [MAT_W-1:0] r12,
  output logic signed [MAT_W-1:0] r20,
  output logic signed [MAT_W-1:0] r21,
  output logic signed [MAT_W-1:0] r22,
  output logic signed [SHF_W-1:0] shift_x,
  output logic signed [SHF_W-1:0] shift_y,
  output logic signed [SHF_W-1:0] shift_z,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  cfg_t   cfg;
  qstat_t qstat;
  logic   push, pop, en, trig_valid;
  item_t  push_item, head;
  trig_t  trig;
  logic signed [MAT_W-1:0] mat [9];
  logic signed [SHF_W-1:0] shf [3];

  // Setup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIR_X:   cfg.u <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:   cfg.v <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:   cfg.w <= cfg_data[DIR_W-1:0];
        REG_POINT_X: cfg.a <= cfg_data[PNT_W-1:0];
        REG_POINT_Y: cfg.b <= cfg_data[PNT_W-1:0];
        REG_POINT_Z: cfg.c <= cfg_data[PNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Back end moves unless a finished item is held
  assign en = !out_valid || !out_stall;

  aart_front u_front (
    .clk, .rst, .in_valid, .in_stall, .angle, .qstat, .push, .push_item
  );

  aart_queue u_queue (
    .clk, .rst, .push, .push_item, .pop, .qstat, .head
  );

  aart_back u_back (
    .clk, .rst, .en, .qstat, .head, .pop, .trig, .trig_valid
  );

  aart_xform u_xform (
    .clk, .rst, .en, .cfg, .trig_valid, .trig, .out_valid, .mat, .shf
  );

  assign r00 = mat[0];
  assign r01 = mat[1];
  assign r02 = mat[2];
  assign r10 = mat[3];
  assign r11 = mat[4];
  assign r12 = mat[5];
  assign r20 = mat[6];
  assign r21 = mat[7];
  assign r22 = mat[8];
  assign shift_x = shf[0];
  assign shift_y = shf[1];
  assign shift_z = shf[2];

endmodule

// ===== rtl/core/aart_checker.sv =====
// Port-level checks for the axis-angle transform unit, bound to the top level.
module aart_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  input logic [31:0] shift_x, shift_y, shift_z
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(r00) && $stable(r01) && $stable(r02)
      && $stable(r10) && $stable(r11) && $stable(r12) && $stable(r20)
      && $stable(r21) && $stable(r22) && $stable(shift_x) && $stable(shift_y)
      && $stable(shift_z))
    else $error("held result changed");

  // Reset empties the pipe and frees the input
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state survived reset");

  // Input backs up only when an item was just offered
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled with no item arriving");

endmodule

bind axis_angle_rigid_transform_unit aart_props u_aart_props (.*);

// ===== sim/aart_checker.sv =====
// Scoreboard for the axis-angle transform unit: predicts each result and compares it.
module aart_checker import aart_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [ANG_W-1:0] angle,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [MAT_W-1:0] r00,
  input  logic signed [MAT_W-1:0] r01,
  input  logic signed [MAT_W-1:0] r02,
  input  logic signed [MAT_W-1:0] r10,
  input  logic signed [MAT_W-1:0] r11,
  input  logic signed [MAT_W-1:0] r12,
  input  logic signed [MAT_W-1:0] r20,
  input  logic signed [MAT_W-1:0] r21,
  input  logic signed [MAT_W-1:0] r22,
  input  logic signed [SHF_W-1:0] shift_x,
  input  logic signed [SHF_W-1:0] shift_y,
  input  logic signed [SHF_W-1:0] shift_z,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint LIM62   = 64'sd4611686018427387904;

  typedef struct packed {
    logic [8:0][MAT_W-1:0] m;
    logic [2:0][SHF_W-1:0] t;
  } pose_t;

  longint ax_u, ax_v, ax_w, ax_a, ax_b, ax_c;
  pose_t  pose_q[$];

  // (p*q) >> n, rounded half away from zero, magnitude capped at 2^62
  function automatic longint mul_round(longint p, longint q, int n);
    logic        neg;
    logic [63:0] mp;
    logic [63:0] mq;
    logic [127:0] prod;
    neg  = (p < 0) != (q < 0);
    mp   = (p < 0) ? 64'(-p) : 64'(p);
    mq   = (q < 0) ? 64'(-q) : 64'(q);
    prod = ({64'd0, mp} * {64'd0, mq} + (128'd1 << (n - 1))) >> n;
    if (prod > 128'(LIM62)) prod = 128'(LIM62);
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint round_sh(longint v, int n);
    logic [63:0] m;
    m = (((v < 0) ? 64'(-v) : 64'(v)) + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [MAT_W-1:0] mat_entry(longint q58);
    longint r;
    r = round_sh(q58, 42);
    if (r > 131071) r = 131071;
    else if (r < -131072) r = -131072;
    return r[MAT_W-1:0];
  endfunction

  function automatic logic [SHF_W-1:0] shift_entry(longint p44, longint q30, longint omc,
                                                   longint sn);
    longint r;
    r = mul_round(p44, omc, 58) + mul_round(q30, sn, 44);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    else if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[SHF_W-1:0];
  endfunction

  // Rotation matrix and translation for one joint angle
  function automatic pose_t rigid_pose(logic signed [ANG_W-1:0] ang);
    pose_t  p;
    longint r, x, x2, cs, sn, omc, c58, sw, su, sv;
    logic   flip;
    r = ang;
    flip = 1'b0;
    cs = Q30_ONE;
    sn = Q30_ONE;
    if (r > longint'(PI28)) r -= longint'(TWOPI28);
    else if (r < -longint'(PI28)) r += longint'(TWOPI28);
    if (r > longint'(HALFPI28)) begin
      r -= longint'(PI28);
      flip = 1'b1;
    end else if (r < -longint'(HALFPI28)) begin
      r += longint'(PI28);
      flip = 1'b1;
    end
    x  = r * 4;
    x2 = mul_round(x, x, 30);
    for (int k = 8; k >= 1; k--) begin
      cs = Q30_ONE - mul_round(x2, cs, 30) / longint'((2 * k - 1) * (2 * k));
      sn = Q30_ONE - mul_round(x2, sn, 30) / longint'((2 * k) * (2 * k + 1));
    end
    sn = mul_round(x, sn, 30);
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    omc = Q30_ONE - cs;
    c58 = cs * 268435456;
    su = ax_u * sn * 16384;
    sv = ax_v * sn * 16384;
    sw = ax_w * sn * 16384;
    p.m[0] = mat_entry(c58 + ax_u * ax_u * omc);
    p.m[1] = mat_entry(ax_u * ax_v * omc - sw);
    p.m[2] = mat_entry(ax_u * ax_w * omc + sv);
    p.m[3] = mat_entry(ax_u * ax_v * omc + sw);
    p.m[4] = mat_entry(c58 + ax_v * ax_v * omc);
    p.m[5] = mat_entry(ax_v * ax_w * omc - su);
    p.m[6] = mat_entry(ax_u * ax_w * omc - sv);
    p.m[7] = mat_entry(ax_v * ax_w * omc + su);
    p.m[8] = mat_entry(c58 + ax_w * ax_w * omc);
    p.t[0] = shift_entry(ax_a * (ax_v * ax_v + ax_w * ax_w)
                         - ax_u * (ax_b * ax_v + ax_c * ax_w),
                         ax_b * ax_w - ax_c * ax_v, omc, sn);
    p.t[1] = shift_entry(ax_b * (ax_u * ax_u + ax_w * ax_w)
                         - ax_v * (ax_a * ax_u + ax_c * ax_w),
                         ax_c * ax_u - ax_a * ax_w, omc, sn);
    p.t[2] = shift_entry(ax_c * (ax_u * ax_u + ax_v * ax_v)
                         - ax_w * (ax_a * ax_u + ax_b * ax_v),
                         ax_a * ax_v - ax_b * ax_u, omc, sn);
    return p;
  endfunction

  assign pending = pose_q.size();

  initial errors = 0;

  // Track the axis setup, queue predictions, compare results
  always @(posedge clk) begin
    pose_t got;
    pose_t want;
    if (rst) begin
      ax_u = 0; ax_v = 0; ax_w = 0;
      ax_a = 0; ax_b = 0; ax_c = 0;
      pose_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.m = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
        got.t = {shift_z, shift_y, shift_x};
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          want = pose_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.m[i] !== want.m[i]) begin
              errors++;
              if (errors <= 10)
                $display("r%0d%0d: expected %0d got %0d", i / 3, i % 3,
                         $signed(want.m[i]), $signed(got.m[i]));
            end
          for (int i = 0; i < 3; i++)
            if (got.t[i] !== want.t[i]) begin
              errors++;
              if (errors <= 10)
                $display("shift[%0d]: expected %0d got %0d", i,
                         $signed(want.t[i]), $signed(got.t[i]));
            end
        end
      end
      if (in_valid && !in_stall) pose_q.push_back(rigid_pose(angle));
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_X:   ax_u = longint'($signed(cfg_data[DIR_W-1:0]));
          REG_DIR_Y:   ax_v = longint'($signed(cfg_data[DIR_W-1:0]));
          REG_DIR_Z:   ax_w = longint'($signed(cfg_data[DIR_W-1:0]));
          REG_POINT_X: ax_a = longint'($signed(cfg_data));
          REG_POINT_Y: ax_b = longint'($signed(cfg_data));
          REG_POINT_Z: ax_c = longint'($signed(cfg_data));
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sim/tb_axis_angle_rigid_transform_unit.sv =====
// Testbench top for the axis-angle transform unit: stimulus, setup phases and verdict.
module tb_axis_angle_rigid_transform_unit import aart_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [ANG_W-1:0] angle;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [MAT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [SHF_W-1:0] shift_x, shift_y, shift_z;
  logic                    cfg_we;
  cfg_idx_t                cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  int                      errors;
  int                      pending;
  int                      idle_pct;
  int                      stall_pct;
  int                      hold_left;
  int                      quiet;

  axis_angle_rigid_transform_unit u_top (.*);

  aart_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls plus one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_angle(logic signed [ANG_W-1:0] a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    angle    <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let the pipe drain before touching the setup
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_axis(logic signed [DIR_W-1:0] u, logic signed [DIR_W-1:0] v,
                          logic signed [DIR_W-1:0] w, logic signed [PNT_W-1:0] a,
                          logic signed [PNT_W-1:0] b, logic signed [PNT_W-1:0] c);
    write_reg(REG_DIR_X, CFG_W'(u));
    write_reg(REG_DIR_Y, CFG_W'(v));
    write_reg(REG_DIR_Z, CFG_W'(w));
    write_reg(REG_POINT_X, a);
    write_reg(REG_POINT_Y, b);
    write_reg(REG_POINT_Z, c);
    @(posedge clk);
  endtask

  // Angles around the reduction boundaries and the field extremes
  task automatic directed_angles;
    logic signed [ANG_W-1:0] pi_a;
    logic signed [ANG_W-1:0] hp_a;
    pi_a = PI28[ANG_W-1:0];
    hp_a = HALFPI28[ANG_W-1:0];
    send_angle(0);
    send_angle(1);
    send_angle(-1);
    send_angle(pi_a);
    send_angle(pi_a + 1);
    send_angle(-pi_a);
    send_angle(-pi_a - 1);
    send_angle(hp_a);
    send_angle(hp_a + 1);
    send_angle(-hp_a);
    send_angle(-hp_a - 1);
    send_angle(32'sh7fffffff);
    send_angle(32'sh80000000);
    send_angle(pi_a >>> 2);
    send_angle(-(pi_a >>> 1) - (pi_a >>> 2));
  endtask

  task automatic random_angles(int n);
    logic signed [ANG_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: a = $urandom_range(32'h7fffffff, 0) - (PI28[ANG_W-1:0]);
        1: a = HALFPI28[ANG_W-1:0] + $signed($urandom_range(64)) - 32;
        2: a = PI28[ANG_W-1:0] - $signed($urandom_range(64)) + 32;
        default: a = $urandom;
      endcase
      if ($urandom_range(1)) a = -a;
      send_angle(a);
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    angle     = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_DIR_X;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    quiet     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setup: zero direction, pure cosine scaling
    directed_angles();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_axis(16'sd16384, 16'sd0, 16'sd0, 32'sd65536, -32'sd131072, 32'sd0);
        1: set_axis(-16'sd32768, -16'sd32768, -16'sd32768,
                    32'sh80000000, 32'sh80000000, 32'sh80000000);
        2: set_axis(16'sd32767, 16'sd32767, 16'sd32767,
                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        3: set_axis(16'sd9459, -16'sd9459, 16'sd9459, 32'sh00123456, -32'sh00345678,
                    32'sh7fffffff);
        default: set_axis(DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom),
                          $urandom, $urandom, $urandom);
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      if (ph == 0) hold_left = 400;
      if (ph < 4) directed_angles();
      random_angles(ph < 4 ? 50 : 60);
      idle_pct  = 0;
      stall_pct = 0;
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
